// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/bslm_pkg.sv =====
`default_nettype none
package bslm_pkg;
  localparam logic [2:0] REG_MIN_RMS = 3'd0;
  localparam logic [2:0] REG_ALPHA = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_LOW = 3'd3;
  localparam logic [2:0] REG_HIGH = 3'd4;
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_QUIET = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic signed [31:0] LOG_SCALE_Q16 = 32'sd50504453;

  typedef enum logic [3:0] {
    S_ACC, S_M1, S_M2, S_M3, S_M4, S_CMP, S_LOGN, S_LOGI, S_LOGS, S_SCALE, S_EMA, S_EMA2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [21:0] result;
  } log_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/bslm_mul.sv =====
`default_nettype none
module bslm_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

// ===== rtl/bslm_log2.sv =====
`default_nettype none
module bslm_log2 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bslm_pkg::log_req_t req,
  output bslm_pkg::log_rsp_t      rsp
);
  import bslm_pkg::*;
  logic [63:0] x;
  logic [5:0] e;
  logic [32:0] m;
  logic [15:0] frac;
  logic [4:0] cnt;
  logic [1:0] phase;
  logic [65:0] sq;
  logic [33:0] msh;

  assign sq = 66'(m) * 66'(m);
  assign msh = sq[64:31];

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (rst) begin
      phase <= 2'd0;
    end else begin
      unique case (phase)
        2'd0: if (req.start) begin
          x <= (req.value == 64'd0) ? 64'd1 : req.value;
          e <= 6'd63;
          phase <= 2'd1;
        end
        2'd1: if (x[63]) begin
          m <= {1'b0, x[63:32]};
          frac <= 16'd0;
          cnt <= 5'd0;
          phase <= 2'd2;
        end else begin
          x <= {x[62:0], 1'b0};
          e <= e - 6'd1;
        end
        2'd2: begin
          if (msh[33:32] != 2'd0) begin
            m <= msh[33:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m <= msh[32:0];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            phase <= 2'd3;
          end
        end
        default: begin
          rsp.done <= 1'b1;
          rsp.result <= {e, frac};
          phase <= 2'd0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/block_sound_level_meter.sv =====
// Flow: a sample without last passes through S_M2, where its square is added, before the input
// is ready again. A sample with last passes through S_M1, S_M3, S_M4 and S_CMP; a quiet or
// zero block gives its result from S_CMP, otherwise two log2 runs, S_LOGS, S_SCALE, S_EMA and
// S_EMA2 follow. The input stays not ready while a result waits to be taken. Block end time
// is set by the shared squaring log2 unit and the 33x33 multiplier. Reset: synchronous
// active-high rst restores config registers and clears counters, sums, smoothing and out_valid.
`default_nettype none
module block_sound_level_meter #(
  parameter int BLOCK_SAMPLES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] sample,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      level,
  output logic                    level_valid,
  output logic [1:0]              status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import bslm_pkg::*;
  `include "assert_macros.svh"
  localparam int CW = $clog2(BLOCK_SAMPLES + 1);

  logic [22:0] min_rms;
  logic [16:0] alpha;
  logic [15:0] offset;
  logic signed [15:0] lo, hi;
  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic signed [31:0] ssum;
  logic [31:0] sabs;
  logic [54:0] qsum;
  logic signed [15:0] smooth;
  logic present;
  logic [63:0] nq, s2, d, thr;
  logic [45:0] mr2;
  logic [16:0] nsq;
  logic [21:0] logd;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [63:0] t;
  logic signed [31:0] x;
  logic signed [63:0] r_raw, r_off, stp;
  log_req_t lreq;
  log_rsp_t lrsp;

  bslm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  bslm_log2 u_log (.clk(clk), .rst(rst), .req(lreq), .rsp(lrsp));

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_ACC) && !out_valid;
  assign sabs = ssum[31] ? 32'(-ssum) : 32'(ssum);
  assign r_raw = (64'(mp) + 64'sd2147483648) >>> 32;
  assign r_off = r_raw + $signed({48'd0, offset});
  assign stp = (64'(mp) + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ma = 33'sd0;
    mb = 33'sd0;
    lreq.start = 1'b0;
    lreq.value = d;
    unique case (state)
      S_ACC: begin
        ma = 33'(sample);
        mb = (cnt < CW'(BLOCK_SAMPLES)) ? 33'(sample) : 33'sd0;
        if (in_valid && in_ready) state_next = last ? S_M1 : S_M2;
      end
      S_M1: begin
        ma = {{(33-CW){1'b0}}, cnt};
        mb = {{(33-CW){1'b0}}, cnt};
        state_next = S_M3;
      end
      S_M2: state_next = S_ACC;
      S_M3: state_next = S_M4;
      S_M4: state_next = S_CMP;
      S_CMP: begin
        if (d < thr || d == 64'd0) state_next = S_OUT;
        else begin
          lreq.start = 1'b1;
          state_next = S_LOGN;
        end
      end
      S_LOGN: if (lrsp.done) begin
        lreq.start = 1'b1;
        lreq.value = thr;
        state_next = S_LOGI;
      end
      S_LOGI: if (lrsp.done) state_next = S_LOGS;
      S_LOGS: begin
        ma = t[32:0];
        mb = 33'(LOG_SCALE_Q16);
        state_next = S_SCALE;
      end
      S_SCALE: state_next = S_EMA;
      S_EMA: begin
        ma = present ? {16'd0, (alpha > 17'd65536) ? 17'd65536 : alpha} : 33'sd0;
        mb = 33'(x) - 33'(smooth);
        state_next = S_EMA2;
      end
      S_EMA2: state_next = S_OUT;
      default: state_next = out_valid ? S_OUT : S_ACC;
    endcase
  end

  // The multiplier squares samples in accumulation, forms N*N at block end, then scales and smooths.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rms <= 23'd0; alpha <= 17'd6554; offset <= 16'd30720;
      lo <= 16'sd0; hi <= 16'sd30720;
      cnt <= '0; ssum <= 32'sd0; qsum <= 55'd0;
      smooth <= 16'sd0; present <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_RMS: min_rms <= cfg_data[22:0];
          REG_ALPHA: alpha <= cfg_data[16:0];
          REG_OFFSET: offset <= cfg_data[15:0];
          REG_LOW: lo <= cfg_data[15:0];
          REG_HIGH: hi <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_ACC: if (in_valid && in_ready && cnt < CW'(BLOCK_SAMPLES)) begin
          cnt <= cnt + CW'(1);
          ssum <= ssum + 32'(sample);
        end
        S_M1: qsum <= qsum + mp[54:0];
        S_M2: qsum <= qsum + mp[54:0];
        S_M3: begin
          nsq <= mp[16:0];
          mr2 <= 46'(min_rms) * 46'(min_rms);
          nq <= 64'(cnt) * 64'(qsum);
          s2 <= 64'(sabs) * 64'(sabs);
        end
        S_M4: begin
          d <= nq - s2;
          thr <= 64'(mr2) * 64'(nsq);
        end
        S_CMP: begin
          thr <= 64'(cnt);
          if (d < thr || d == 64'd0) begin
            status <= (d < thr) ? ST_QUIET : ST_ZERO;
            out_valid <= 1'b1;
            cnt <= '0; ssum <= 32'sd0; qsum <= 55'd0;
          end
        end
        S_LOGN: if (lrsp.done) logd <= lrsp.result;
        S_LOGI: if (lrsp.done)
          t <= 64'(logd) - 64'(2 * 64'(lrsp.result)) - 64'(46 * 65536);
        S_SCALE: begin
          if (r_off > 64'sd32767) x <= 32'sd32767;
          else if (r_off < -64'sd32768) x <= -32'sd32768;
          else x <= r_off[31:0];
        end
        S_EMA2: begin
          smooth <= present ? smooth + stp[15:0] : x[15:0];
          present <= 1'b1;
          out_valid <= 1'b1;
          status <= ST_UPDATED;
          cnt <= '0; ssum <= 32'sd0; qsum <= 55'd0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    level = smooth;
  end
  assign level_valid = (status == ST_UPDATED) && (smooth >= lo) && (smooth <= hi);

  `ASSERT_NEXT(a_acc_one, clk, rst, in_valid && in_ready && !last, cnt <= CW'(BLOCK_SAMPLES))
  `ASSERT_IMPL(a_busy, clk, rst, !(out_valid && in_ready))
  `ASSERT_IMPL(a_stat, clk, rst, !out_valid || status == ST_UPDATED || status == ST_QUIET || status == ST_ZERO)
endmodule
`default_nettype wire
